/* src/color_organ_peak_autocal_assert.svh */
// Assertion macros for the color organ peak auto-calibration block.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef COLOR_ORGAN_PEAK_AUTOCAL_ASSERT_SVH
`define COLOR_ORGAN_PEAK_AUTOCAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define COPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("copa assertion failed");
// next-cycle implication
`define COPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("copa assertion failed");
`else
`define COPA_ASSERT_IMPL(label, ante, cons)
`define COPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/copa_pkg.sv */
// Shared constants, payload structs and divider result type for the
// color organ peak auto-calibration block. No dependencies.
package copa_pkg;

    localparam int FIELD_W       = 24;
    localparam int LEVEL_BITS    = 24;
    localparam int FRAC_SHIFT    = 8;                       // Q24.0 -> Q24.8
    localparam int CAL_W         = LEVEL_BITS + FRAC_SHIFT;
    localparam int QUOT_BITS     = 8;
    localparam int NUM_W         = CAL_W + QUOT_BITS;
    localparam int STEP_W        = $clog2(QUOT_BITS + 1);
    localparam int WARMUP_FRAMES = 10;
    localparam int WARM_W        = 4;
    localparam int FULL_SCALE    = 100;
    localparam int BRIGHT_W      = 7;
    localparam int DECAY_NUM     = 65529;
    localparam int DECAY_SHIFT   = 16;
    localparam int PROD_W        = CAL_W + DECAY_SHIFT;
    localparam int NBANDS        = 3;
    localparam int BAND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CAL_INIT_RST  = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTOCAL   = 2'd0,
        CFG_LOW_INIT  = 2'd1,
        CFG_MID_INIT  = 2'd2,
        CFG_HIGH_INIT = 2'd3
    } copa_cfg_idx_t;

    typedef struct packed {
        logic               new_song;
        logic [FIELD_W-1:0] low_level;
        logic [FIELD_W-1:0] mid_level;
        logic [FIELD_W-1:0] high_level;
    } copa_in_t;

    typedef struct packed {
        logic                leds_valid;
        logic [BRIGHT_W-1:0] red_brightness;
        logic [BRIGHT_W-1:0] green_brightness;
        logic [BRIGHT_W-1:0] blue_brightness;
        logic                cal_raised;
        logic                clipped;
    } copa_out_t;

    typedef struct packed {
        logic                 ovf;     // num >= den << QUOT_BITS
        logic [QUOT_BITS-1:0] quot;
        logic                 rem_nz;
    } copa_div_res_t;

endpackage

/* src/copa_div.sv */
// Iterative restoring divider, one quotient bit per cycle, with an
// overflow check in the first step. Depends on copa_pkg.
module copa_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [copa_pkg::NUM_W-1:0]     num,
    input  logic [copa_pkg::CAL_W-1:0]     den,
    output logic                           done,
    output copa_pkg::copa_div_res_t        res
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [copa_pkg::STEP_W-1:0]        step_reg;
    logic [copa_pkg::NUM_W-1:0]         rem_reg;
    logic [copa_pkg::NUM_W-1:0]         dsr_reg;
    logic [copa_pkg::QUOT_BITS-1:0]     quot_reg;
    logic                               ovf_reg;
    logic                               ge;

    assign ge = (rem_reg >= dsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= copa_pkg::STEP_W'(copa_pkg::QUOT_BITS);
            end
            else if (busy_reg)
            begin
                if ((step_reg == copa_pkg::STEP_W'(copa_pkg::QUOT_BITS) && ge) ||
                    step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsr_reg  <= copa_pkg::NUM_W'(den) << copa_pkg::QUOT_BITS;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (step_reg == copa_pkg::STEP_W'(copa_pkg::QUOT_BITS))
            begin
                // overflow probe only, nothing subtracted
                ovf_reg <= ge;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsr_reg;
                end
                quot_reg <= {quot_reg[copa_pkg::QUOT_BITS-2:0], ge};
            end
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done       = done_reg;
    assign res.ovf    = ovf_reg;
    assign res.quot   = quot_reg;
    assign res.rem_nz = (rem_reg != '0);

endmodule

/* src/color_organ_peak_autocal.sv */
// Color organ with peak-following auto gain: top level, sequencer and state.
// Depends on copa_pkg, copa_div and color_organ_peak_autocal_assert.svh.
//
// One frame of three band levels gives one result. A warm-up frame goes from
// idle straight to S_DONE, which loads its result into the output register. In
// auto mode a normal frame first updates the calibration of each of the three
// bands in turn; with fixed calibrations this is skipped. Then three divisions
// run one after another on the single shared divider. Each division is made up
// of launch, nine divider steps and hand-back. A band whose ratio is 256 or more
// stops after the first divider step. in_ready is high only while the sequencer
// is idle. A finished result sits in the output register while the next request
// is taken. The sequencer stalls before loading a new result while the previous
// one is still waiting. Configuration writes are accepted every cycle. New
// calibration init values apply at the next new_song frame. No clearing pass
// after reset.
`include "color_organ_peak_autocal_assert.svh"

module color_organ_peak_autocal
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  copa_pkg::copa_in_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output copa_pkg::copa_out_t                out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [copa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [copa_pkg::FIELD_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    state_t                              state_reg;
    logic [copa_pkg::BAND_W-1:0]         band_reg;
    logic [copa_pkg::WARM_W-1:0]         warmup_reg;
    logic                                autocal_reg;
    logic [copa_pkg::FIELD_W-1:0]        cal_init_reg [copa_pkg::NBANDS];
    logic [copa_pkg::CAL_W-1:0]          band_cal_reg [copa_pkg::NBANDS];
    logic [copa_pkg::FIELD_W-1:0]        level_reg    [copa_pkg::NBANDS];
    logic [copa_pkg::BRIGHT_W-1:0]       bright_reg   [copa_pkg::NBANDS];
    logic                                leds_reg;
    logic                                raised_reg;
    logic                                clip_reg;
    logic                                out_valid_reg;
    copa_pkg::copa_out_t                 out_item_reg;

    logic                                in_fire;
    logic [copa_pkg::WARM_W-1:0]         warm_eff;
    logic [copa_pkg::FIELD_W-1:0]        in_level [copa_pkg::NBANDS];
    logic [copa_pkg::CAL_W-1:0]          lvl_q;
    logic [copa_pkg::CAL_W-1:0]          cal_cur;
    logic [copa_pkg::PROD_W-1:0]         decay_prod;
    logic [copa_pkg::CAL_W-1:0]          cal_upd;
    logic                                peak;
    logic [copa_pkg::NUM_W-1:0]          div_num;
    logic                                div_start;
    logic                                div_done;
    copa_pkg::copa_div_res_t             div_res;
    logic                                lvl_zero;
    logic                                div_clip;
    logic [copa_pkg::BRIGHT_W-1:0]       band_bright;
    logic                                last_band;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign in_level[0] = in_item.low_level;
    assign in_level[1] = in_item.mid_level;
    assign in_level[2] = in_item.high_level;

    assign warm_eff  = in_item.new_song ? '0 : warmup_reg;
    assign last_band = (band_reg == copa_pkg::BAND_W'(copa_pkg::NBANDS - 1));

    // calibration update for the current band
    assign lvl_q      = copa_pkg::CAL_W'(level_reg[band_reg]) << copa_pkg::FRAC_SHIFT;
    assign cal_cur    = band_cal_reg[band_reg];
    assign decay_prod = copa_pkg::PROD_W'(cal_cur) *
                        copa_pkg::PROD_W'(copa_pkg::DECAY_NUM);
    assign peak       = (lvl_q > cal_cur);
    assign cal_upd    = peak ? lvl_q
                             : decay_prod[copa_pkg::PROD_W-1:copa_pkg::DECAY_SHIFT];

    assign div_num   = copa_pkg::NUM_W'(lvl_q) * copa_pkg::NUM_W'(copa_pkg::FULL_SCALE);
    assign div_start = (state_reg == S_DIV_GO);

    // clip when the exact ratio exceeds full scale (zero cal with nonzero level too)
    assign lvl_zero = (level_reg[band_reg] == '0);
    assign div_clip = div_res.ovf ||
                      (div_res.quot > copa_pkg::QUOT_BITS'(copa_pkg::FULL_SCALE)) ||
                      ((div_res.quot == copa_pkg::QUOT_BITS'(copa_pkg::FULL_SCALE)) &&
                       div_res.rem_nz);

    always_comb
    begin
        if (lvl_zero)
        begin
            band_bright = '0;
        end
        else if (div_clip)
        begin
            band_bright = copa_pkg::BRIGHT_W'(copa_pkg::FULL_SCALE);
        end
        else
        begin
            band_bright = div_res.quot[copa_pkg::BRIGHT_W-1:0];
        end
    end

    copa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cal_cur),
        .done  (div_done),
        .res   (div_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autocal_reg <= 1'b1;
            for (int b = 0; b < copa_pkg::NBANDS; b++)
            begin
                cal_init_reg[b] <= copa_pkg::FIELD_W'(copa_pkg::CAL_INIT_RST);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (copa_pkg::copa_cfg_idx_t'(cfg_index))
                copa_pkg::CFG_AUTOCAL:   autocal_reg     <= cfg_data[0];
                copa_pkg::CFG_LOW_INIT:  cal_init_reg[0] <= cfg_data;
                copa_pkg::CFG_MID_INIT:  cal_init_reg[1] <= cfg_data;
                copa_pkg::CFG_HIGH_INIT: cal_init_reg[2] <= cfg_data;
            endcase
        end
    end

    // frame payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int b = 0; b < copa_pkg::NBANDS; b++)
            begin
                level_reg[b] <= in_level[b];
            end
        end
    end

    // sequencer, calibration state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            band_reg      <= '0;
            warmup_reg    <= '0;
            leds_reg      <= 1'b0;
            raised_reg    <= 1'b0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            for (int b = 0; b < copa_pkg::NBANDS; b++)
            begin
                band_cal_reg[b] <= copa_pkg::CAL_W'(copa_pkg::CAL_INIT_RST)
                                   << copa_pkg::FRAC_SHIFT;
                bright_reg[b]   <= '0;
            end
        end
        else
        begin
            // S_DONE reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        band_reg   <= '0;
                        raised_reg <= 1'b0;
                        clip_reg   <= 1'b0;
                        if (in_item.new_song)
                        begin
                            for (int b = 0; b < copa_pkg::NBANDS; b++)
                            begin
                                band_cal_reg[b] <= copa_pkg::CAL_W'(cal_init_reg[b])
                                                   << copa_pkg::FRAC_SHIFT;
                            end
                        end
                        if (warm_eff < copa_pkg::WARM_W'(copa_pkg::WARMUP_FRAMES))
                        begin
                            warmup_reg <= warm_eff + 1'b1;
                            leds_reg   <= 1'b0;
                            for (int b = 0; b < copa_pkg::NBANDS; b++)
                            begin
                                bright_reg[b] <= '0;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            warmup_reg <= warm_eff;
                            leds_reg   <= 1'b1;
                            state_reg  <= autocal_reg ? S_CAL : S_DIV_GO;
                        end
                    end
                end

                S_CAL:
                begin
                    band_cal_reg[band_reg] <= cal_upd;
                    raised_reg             <= raised_reg | peak;
                    if (last_band)
                    begin
                        band_reg  <= '0;
                        state_reg <= S_DIV_GO;
                    end
                    else
                    begin
                        band_reg <= band_reg + 1'b1;
                    end
                end

                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        bright_reg[band_reg] <= band_bright;
                        clip_reg             <= clip_reg | (!lvl_zero && div_clip);
                        if (last_band)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            band_reg  <= band_reg + 1'b1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg                 <= 1'b1;
                        out_item_reg.leds_valid       <= leds_reg;
                        out_item_reg.red_brightness   <= bright_reg[0];
                        out_item_reg.green_brightness <= bright_reg[1];
                        out_item_reg.blue_brightness  <= bright_reg[2];
                        out_item_reg.cal_raised       <= raised_reg;
                        out_item_reg.clipped          <= clip_reg;
                        state_reg                     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `COPA_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready)
    `COPA_ASSERT_IMPL(a_warmup_bounded, 1'b1, warmup_reg <= copa_pkg::WARM_W'(10))
    `COPA_ASSERT_IMPL(a_warmup_result_blank, out_valid && !out_item.leds_valid, out_item == '0)
    `COPA_ASSERT_IMPL(a_div_only_when_waiting, div_done, state_reg == S_DIV_WAIT)

endmodule
